// ===== rtl/hsvg_pkg.sv =====
`timescale 1ns / 1ps
// hsvg_pkg: shared widths, constants, dimming curve and pipeline stage types
// for the hsv_to_rgb_gamma converter. no dependencies.
package hsvg_pkg;

   localparam int HUE_W  = 9;
   localparam int CHAN_W = 8;
   localparam int FRAC_W = 6;
   localparam int PROD_W = CHAN_W + FRAC_W;

   localparam int HUE_SECTOR  = 60;
   localparam int HUE_CIRCLE  = 360;
   localparam int FULL_SCALE  = 255;

   // x / 60 == (x * DIV60_MULT) >> DIV60_SHIFT for every x below 2**PROD_W
   localparam int DIV60_SHIFT = 20;
   localparam int DIV60_MULT  = ((1 << DIV60_SHIFT) + HUE_SECTOR - 1) / HUE_SECTOR;
   localparam int DIV60_MW    = 15;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   localparam logic [CHAN_W-1:0] GAMMA_ROM [0:255] = '{
      8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
      8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
      8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
      8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
      8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
      8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
      8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
      8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
      8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
      8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
      8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
      8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
      8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
      8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
      8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
      8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
      8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
      8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
      8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
      8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
      8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
      8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
      8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
      8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
   };

   // after lookup and hue split
   typedef struct packed {
      logic [CHAN_W-1:0] v;
      logic [CHAN_W-1:0] gs;
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic              grey;
   } s1_type;

   // after base multiply
   typedef struct packed {
      logic [CHAN_W-1:0] v;
      logic [CHAN_W-1:0] base;
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic              grey;
   } s2_type;

   // after ramp products
   typedef struct packed {
      logic [CHAN_W-1:0] v;
      logic [CHAN_W-1:0] base;
      logic [PROD_W-1:0] prod_up;
      logic [PROD_W-1:0] prod_down;
      sector_type        sector;
      logic              grey;
   } s3_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

endpackage

// ===== rtl/hsvg_if.sv =====
`timescale 1ns / 1ps
// hsvg_req_if / hsvg_rsp_if: valid-ready channels for hsv words in and rgb words out.
// depends on hsvg_pkg.
interface hsvg_req_if
   import hsvg_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsvg_rsp_if
   import hsvg_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/hsv_to_rgb_gamma.sv =====
`timescale 1ns / 1ps
// hsv_to_rgb_gamma: pipelined hsv to rgb converter with dimming curve.
// depends on hsvg_pkg, hsvg_req_if, hsvg_rsp_if and hsvg_div60.
//
// Takes one hsv word per clock when not stalled and returns one rgb word per word taken,
// in order. The four register stages are the dimming lookup with hue sector split, the
// 8x8 base multiply, the two ramp multiplies, and the reciprocal divide by 60 with
// channel select; the last stage is the output register.
// Each stage holds its word while the one after it is full and stalled, so the input
// keeps taking words as long as a stage has room. Hues of 360 and above wrap round the
// circle; a saturation of zero gives grey.
module hsv_to_rgb_gamma
   import hsvg_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   hsvg_req_if.sink    req,
   hsvg_rsp_if.source  rsp
);

   logic    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic    adv1, adv2, adv3, adv4;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   rgb_type s4_ff, s4_in;

   logic [HUE_W-1:0]    hue_wrap;
   logic [HUE_W-1:0]    hue_off;
   logic [2*CHAN_W-1:0] base_prod;
   logic [CHAN_W-1:0]   diff;
   logic [FRAC_W-1:0]   frac_down;
   logic [CHAN_W-1:0]   quot_up, quot_down;
   logic [CHAN_W-1:0]   up, down;

   // stall chain
   assign adv4      = !s4_valid_ff || rsp.ready;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req.ready = adv1;

   // stage 1: dimming lookup, hue wrap and sector split
   always_comb begin
      hue_wrap = (req.hue >= HUE_W'(HUE_CIRCLE)) ? req.hue - HUE_W'(HUE_CIRCLE) : req.hue;
      priority if (hue_wrap < HUE_W'(HUE_SECTOR)) begin
         s1_in.sector = SECTOR_0;
         hue_off      = hue_wrap;
      end else if (hue_wrap < HUE_W'(2 * HUE_SECTOR)) begin
         s1_in.sector = SECTOR_1;
         hue_off      = hue_wrap - HUE_W'(HUE_SECTOR);
      end else if (hue_wrap < HUE_W'(3 * HUE_SECTOR)) begin
         s1_in.sector = SECTOR_2;
         hue_off      = hue_wrap - HUE_W'(2 * HUE_SECTOR);
      end else if (hue_wrap < HUE_W'(4 * HUE_SECTOR)) begin
         s1_in.sector = SECTOR_3;
         hue_off      = hue_wrap - HUE_W'(3 * HUE_SECTOR);
      end else if (hue_wrap < HUE_W'(5 * HUE_SECTOR)) begin
         s1_in.sector = SECTOR_4;
         hue_off      = hue_wrap - HUE_W'(4 * HUE_SECTOR);
      end else begin
         s1_in.sector = SECTOR_5;
         hue_off      = hue_wrap - HUE_W'(5 * HUE_SECTOR);
      end
      s1_in.frac = hue_off[FRAC_W-1:0];
      s1_in.v    = GAMMA_ROM[req.brightness];
      s1_in.gs   = GAMMA_ROM[~req.saturation];
      // corrected saturation is zero only when the curve gives full scale
      s1_in.grey = (s1_in.gs == CHAN_W'(FULL_SCALE));
   end

   // stage 2: base level
   always_comb begin
      base_prod     = (2*CHAN_W)'(s1_ff.gs) * (2*CHAN_W)'(s1_ff.v);
      s2_in.v       = s1_ff.v;
      s2_in.base    = base_prod[2*CHAN_W-1:CHAN_W];
      s2_in.sector  = s1_ff.sector;
      s2_in.frac    = s1_ff.frac;
      s2_in.grey    = s1_ff.grey;
   end

   // stage 3: ramp products
   always_comb begin
      diff            = s2_ff.v - s2_ff.base;
      frac_down       = FRAC_W'(HUE_SECTOR) - s2_ff.frac;
      s3_in.v         = s2_ff.v;
      s3_in.base      = s2_ff.base;
      s3_in.prod_up   = PROD_W'(diff) * PROD_W'(s2_ff.frac);
      s3_in.prod_down = PROD_W'(diff) * PROD_W'(frac_down);
      s3_in.sector    = s2_ff.sector;
      s3_in.grey      = s2_ff.grey;
   end

   // stage 4: divide by 60 and channel select
   hsvg_div60 u_div_up (
      .dividend (s3_ff.prod_up),
      .quotient (quot_up)
   );

   hsvg_div60 u_div_down (
      .dividend (s3_ff.prod_down),
      .quotient (quot_down)
   );

   always_comb begin
      up   = quot_up + s3_ff.base;
      down = quot_down + s3_ff.base;
      if (s3_ff.grey) begin
         s4_in = '{red: s3_ff.v, green: s3_ff.v, blue: s3_ff.v};
      end else begin
         unique case (s3_ff.sector)
            SECTOR_0: s4_in = '{red: s3_ff.v,    green: up,         blue: s3_ff.base};
            SECTOR_1: s4_in = '{red: down,       green: s3_ff.v,    blue: s3_ff.base};
            SECTOR_2: s4_in = '{red: s3_ff.base, green: s3_ff.v,    blue: up};
            SECTOR_3: s4_in = '{red: s3_ff.base, green: down,       blue: s3_ff.v};
            SECTOR_4: s4_in = '{red: up,         green: s3_ff.base, blue: s3_ff.v};
            default:  s4_in = '{red: s3_ff.v,    green: s3_ff.base, blue: down};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req.valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req.valid)   s1_ff <= s1_in;
      if (adv2 && s1_valid_ff) s2_ff <= s2_in;
      if (adv3 && s2_valid_ff) s3_ff <= s3_in;
      if (adv4 && s3_valid_ff) s4_ff <= s4_in;
   end

   assign rsp.valid = s4_valid_ff;
   assign rsp.red   = s4_ff.red;
   assign rsp.green = s4_ff.green;
   assign rsp.blue  = s4_ff.blue;

endmodule

// ===== rtl/hsvg_div60.sv =====
`timescale 1ns / 1ps
// hsvg_div60: truncating divide by 60 of a ramp product by reciprocal multiply.
// depends on hsvg_pkg.
module hsvg_div60
   import hsvg_pkg::*;
   (
   input  logic [PROD_W-1:0] dividend,
   output logic [CHAN_W-1:0] quotient
);

   localparam int FULL_W = PROD_W + DIV60_MW;

   logic [FULL_W-1:0] product;

   // quotient never exceeds a byte: the largest ramp product is 255 * 60
   assign product  = FULL_W'(dividend) * FULL_W'(DIV60_MULT);
   assign quotient = product[DIV60_SHIFT +: CHAN_W];

endmodule
